// ----- rtl/gms_pkg.sv -----
package gms_pkg;

   // default sizes of the line store and the grid
   localparam int MAX_COLS_DEF = 256;
   localparam int MAX_ROWS_DEF = 4096;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 13;
   localparam int COLS_W     = 9;
   localparam int ROWS_W     = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 1'd1;

   // payload widths
   localparam int COORD_W = 32;
   localparam int COL_W   = 8;
   localparam int ROW_W   = 12;

   // saturation limits
   localparam logic signed [31:0] SAT_POS = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] SAT_NEG = 32'sh8000_0000;
   localparam logic signed [31:0] DER_LIM = 32'sh7FFF_FFFF;

   // reciprocal divider: numerator 2^48 + |d|/2, divisor |d|
   localparam int DIV_NUM_W = 64;
   localparam int DIV_DEN_W = 63;
   localparam int DIV_Q_W   = 49;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_ctl_type;

   typedef struct packed {
      logic               done;
      logic [DIV_Q_W-1:0] quo;
   } div_sts_type;

endpackage

// ----- rtl/gms_if.sv -----
interface gms_req_if import gms_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] x_coord;
   logic signed [COORD_W-1:0] y_coord;

   modport source (output valid, output x_coord, output y_coord, input ready);
   modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface gms_rsp_if import gms_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COL_W-1:0]   col_index;
   logic [ROW_W-1:0]   row_index;
   logic signed [31:0] inverse_det;
   logic signed [31:0] xi_x;
   logic signed [31:0] xi_y;
   logic signed [31:0] eta_x;
   logic signed [31:0] eta_y;
   logic               singular;
   logic               last;

   modport source (output valid, output col_index, output row_index, output inverse_det,
                   output xi_x, output xi_y, output eta_x, output eta_y,
                   output singular, output last, input ready);
   modport sink   (input valid, input col_index, input row_index, input inverse_det,
                   input xi_x, input xi_y, input eta_x, input eta_y,
                   input singular, input last, output ready);
endinterface

// ----- rtl/grid_metric_stencil.sv -----
// channel | dir | beat contents                                 | beat taken when
// req     | in  | x_coord, y_coord (Q16.16, row-major points)   | req.valid & req.ready
// rsp     | out | col/row index, inverse_det, four metrics,     | rsp.valid & rsp.ready
//         |     | singular, last                                |
// csr     | in  | csr_index, csr_data                           | csr_wr_en
//
// each point beat is written into the three-row line store; it
// then causes zero to three result beats, each worked out with the
// 49-step reciprocal divider (unless singular), four store reads and six multiplier passes
// a point that causes no result leaves req.ready high
// req.ready is low while results of the last point are being worked out
// synchronous reset; the line store is not cleared and is only read after written
// a stalled rsp holds the sequencer before it loads the output register
module grid_metric_stencil import gms_pkg::*; #(
   parameter int MAX_COLS = MAX_COLS_DEF,
   parameter int MAX_ROWS = MAX_ROWS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   gms_req_if.sink               req,
   gms_rsp_if.source             rsp,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int CW    = $clog2(MAX_COLS);
   localparam int RW    = $clog2(MAX_ROWS);
   localparam int DEPTH = 3 * MAX_COLS;
   localparam int AW    = $clog2(DEPTH);

   typedef enum logic [3:0] {
      S_IDLE, S_JOB, S_RD, S_DET, S_DIVS, S_DIVW, S_MET, S_OUT
   } state_type;

   // line store address: row slot times row length plus column
   function automatic logic [AW-1:0] mk_addr(input logic [1:0] s, input logic [CW-1:0] c);
      return AW'(AW'(s) * AW'(MAX_COLS)) + AW'(c);
   endfunction

   // difference, optionally halved toward zero, saturated to the derivative range
   function automatic logic signed [31:0] deriv(input logic signed [31:0] a,
                                                input logic signed [31:0] b,
                                                input logic half);
      logic signed [32:0] d;
      logic signed [32:0] h;
      d = 33'(a) - 33'(b);
      h = half ? ((d + $signed({32'd0, d[32]})) >>> 1) : d;
      if (h > 33'(DER_LIM)) return DER_LIM;
      if (h < -33'(DER_LIM)) return -DER_LIM;
      return 32'(h);
   endfunction

   // round to nearest (ties up) from Q32.32 to Q16.16, then saturate
   function automatic logic signed [31:0] rsat(input logic signed [63:0] p);
      logic signed [63:0] v;
      v = (p + 64'sd32768) >>> 16;
      if (v > 64'(SAT_POS)) return SAT_POS;
      if (v < 64'(SAT_NEG)) return SAT_NEG;
      return 32'(v);
   endfunction

   state_type             state_ff;
   logic [COLS_W-1:0]     cols_ff;
   logic [ROWS_W-1:0]     rows_ff;
   logic [CW-1:0]         col_ff;
   logic [RW-1:0]         row_ff;
   logic [1:0]            slot_ff;
   logic [CW-1:0]         acc_col_ff;
   logic [RW-1:0]         acc_row_ff;
   logic [1:0]            acc_slot_ff;
   logic [2:0]            pend_ff;
   logic [2:0]            cnt_ff;
   logic [AW-1:0]         adr_ff [4];
   logic                  half_xi_ff;
   logic                  half_eta_ff;
   logic [CW-1:0]         ecol_ff;
   logic [RW-1:0]         erow_ff;
   logic                  elast_ff;
   logic [63:0]           hold_ff;
   logic signed [31:0]    xk_ff, yk_ff, xe_ff, ye_ff;
   logic signed [63:0]    prod_ff;
   logic signed [63:0]    p1_ff;
   logic signed [63:0]    det_ff;
   logic signed [31:0]    inv_ff;
   logic                  sing_ff;
   logic signed [31:0]    met_ff [4];

   // line store
   logic [63:0]           mem [DEPTH];
   logic [63:0]           rd_data_ff;
   logic [AW-1:0]         rd_addr;
   logic                  mem_we;
   logic [AW-1:0]         wr_addr;

   // output register
   logic                  rsp_valid_ff;
   logic [COL_W-1:0]      rsp_col_ff;
   logic [ROW_W-1:0]      rsp_row_ff;
   logic signed [31:0]    rsp_inv_ff;
   logic signed [31:0]    rsp_met_ff [4];
   logic                  rsp_sing_ff;
   logic                  rsp_last_ff;

   // grid limits after clamping
   logic [31:0]           cols32, rows32;
   logic [CW:0]           nc;
   logic [RW:0]           nr;
   logic [CW-1:0]         ncm1;
   logic [RW-1:0]         nrm1;

   // position of an accepted point
   logic                  wrap;
   logic [CW-1:0]         c0;
   logic [RW-1:0]         r0;
   logic [1:0]            s0;
   logic                  c_end, r_end;
   logic [2:0]            pend_new;

   // job decode
   logic [1:0]            sel;
   logic [2:0]            sel_mask;
   logic [1:0]            sm1, sp1;
   logic [CW-1:0]         j_col;
   logic [RW-1:0]         j_row;
   logic [1:0]            j_slot, j_up, j_dn;
   logic                  j_last;
   logic [AW-1:0]         j_adr [4];
   logic                  j_half_xi, j_half_eta;

   // shared multiplier and divider
   logic signed [31:0]    mop_a, mop_b;
   logic signed [31:0]    term_cur, term_prev;
   logic [DIV_DEN_W-1:0]  mag;
   logic                  det_zero;
   div_ctl_type           div_ctl;
   div_sts_type           div_sts;

   always_comb begin
      cols32 = 32'(cols_ff);
      rows32 = 32'(rows_ff);
      if (cols32 < 32'd3)                nc = (CW+1)'(3);
      else if (cols32 > 32'(MAX_COLS))   nc = (CW+1)'(MAX_COLS);
      else                               nc = (CW+1)'(cols32);
      if (rows32 < 32'd3)                nr = (RW+1)'(3);
      else if (rows32 > 32'(MAX_ROWS))   nr = (RW+1)'(MAX_ROWS);
      else                               nr = (RW+1)'(rows32);
      ncm1 = CW'(nc - 1'b1);
      nrm1 = RW'(nr - 1'b1);
   end

   // point position, restarting when the limits shrank under the counters
   always_comb begin
      wrap     = ({1'b0, col_ff} >= nc) || ({1'b0, row_ff} >= nr);
      c0       = wrap ? '0 : col_ff;
      r0       = wrap ? '0 : row_ff;
      s0       = wrap ? 2'd0 : slot_ff;
      c_end    = (c0 == ncm1);
      r_end    = (r0 == nrm1);
      // results: point above, left neighbor on last row, this point at grid end
      pend_new = {r_end && c_end, r_end && (c0 != '0), r0 != '0};
      mem_we   = (state_ff == S_IDLE) && req.valid;
      wr_addr  = mk_addr(s0, c0);
   end

   assign req.ready = (state_ff == S_IDLE);

   // pick the oldest pending result and work out its four store reads
   always_comb begin
      if (pend_ff[0])      sel = 2'd0;
      else if (pend_ff[1]) sel = 2'd1;
      else                 sel = 2'd2;
      sel_mask = 3'b001 << sel;
      sm1 = (acc_slot_ff == 2'd0) ? 2'd2 : acc_slot_ff - 2'd1;
      sp1 = (acc_slot_ff == 2'd2) ? 2'd0 : acc_slot_ff + 2'd1;
      case (sel)
         2'd0: begin
            j_col  = acc_col_ff;
            j_row  = acc_row_ff - 1'b1;
            j_slot = sm1;
            j_up   = acc_slot_ff;
            j_dn   = sp1;
            j_last = 1'b0;
         end
         2'd1: begin
            j_col  = acc_col_ff - 1'b1;
            j_row  = acc_row_ff;
            j_slot = acc_slot_ff;
            j_up   = acc_slot_ff;
            j_dn   = sm1;
            j_last = 1'b0;
         end
         default: begin
            j_col  = acc_col_ff;
            j_row  = acc_row_ff;
            j_slot = acc_slot_ff;
            j_up   = acc_slot_ff;
            j_dn   = sm1;
            j_last = 1'b1;
         end
      endcase
      // along the row: one-sided on both edges, halved central inside
      if (j_col == '0) begin
         j_adr[0]  = mk_addr(j_slot, CW'(1));
         j_adr[1]  = mk_addr(j_slot, '0);
         j_half_xi = 1'b0;
      end else if (j_col == ncm1) begin
         j_adr[0]  = mk_addr(j_slot, j_col);
         j_adr[1]  = mk_addr(j_slot, j_col - 1'b1);
         j_half_xi = 1'b0;
      end else begin
         j_adr[0]  = mk_addr(j_slot, j_col + 1'b1);
         j_adr[1]  = mk_addr(j_slot, j_col - 1'b1);
         j_half_xi = 1'b1;
      end
      // across rows: first row reads slots one and zero
      if (j_row == '0) begin
         j_adr[2]   = mk_addr(2'd1, j_col);
         j_adr[3]   = mk_addr(2'd0, j_col);
         j_half_eta = 1'b0;
      end else if (j_row == nrm1) begin
         j_adr[2]   = mk_addr(j_slot, j_col);
         j_adr[3]   = mk_addr(j_dn, j_col);
         j_half_eta = 1'b0;
      end else begin
         j_adr[2]   = mk_addr(j_up, j_col);
         j_adr[3]   = mk_addr(j_dn, j_col);
         j_half_eta = 1'b1;
      end
   end

   // metric terms in output order
   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    term_cur = ye_ff;
         2'd1:    term_cur = -xe_ff;
         2'd2:    term_cur = -yk_ff;
         default: term_cur = xk_ff;
      endcase
      case (cnt_ff[1:0] - 2'd1)
         2'd0:    term_prev = ye_ff;
         2'd1:    term_prev = -xe_ff;
         2'd2:    term_prev = -yk_ff;
         default: term_prev = xk_ff;
      endcase
   end

   // multiplier operands: two determinant products, then four metrics
   always_comb begin
      mop_a = '0;
      mop_b = '0;
      if (state_ff == S_DET) begin
         mop_a = (cnt_ff == 3'd0) ? xk_ff : yk_ff;
         mop_b = (cnt_ff == 3'd0) ? ye_ff : xe_ff;
      end else if (state_ff == S_MET) begin
         mop_a = inv_ff;
         mop_b = term_cur;
      end
   end

   always_comb begin
      det_zero      = (det_ff == '0);
      mag           = det_ff[63] ? DIV_DEN_W'(-det_ff) : DIV_DEN_W'(det_ff);
      div_ctl.start = (state_ff == S_DIVS) && !det_zero;
      div_ctl.num   = (DIV_NUM_W'(1) << 48) + DIV_NUM_W'(mag >> 1);
      div_ctl.den   = mag;
      rd_addr       = adr_ff[cnt_ff[1:0]];
   end

   gms_div u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .sts   (div_sts)
   );

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= {req.y_coord, req.x_coord};
      end
      rd_data_ff <= mem[rd_addr];
      prod_ff    <= mop_a * mop_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cols_ff      <= COLS_W'(MAX_COLS_DEF);
         rows_ff      <= ROWS_W'(MAX_ROWS_DEF);
         col_ff       <= '0;
         row_ff       <= '0;
         slot_ff      <= 2'd0;
         pend_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         // a write to either register restarts the grid
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_COLS: cols_ff <= csr_data[COLS_W-1:0];
               CSR_ROWS: rows_ff <= csr_data[ROWS_W-1:0];
               default: ;
            endcase
            col_ff  <= '0;
            row_ff  <= '0;
            slot_ff <= 2'd0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req.valid) begin
                  acc_col_ff  <= c0;
                  acc_row_ff  <= r0;
                  acc_slot_ff <= s0;
                  pend_ff     <= pend_new;
                  if (c_end) begin
                     col_ff <= '0;
                     if (r_end) begin
                        row_ff  <= '0;
                        slot_ff <= 2'd0;
                     end else begin
                        row_ff  <= r0 + 1'b1;
                        slot_ff <= (s0 == 2'd2) ? 2'd0 : s0 + 2'd1;
                     end
                  end else begin
                     col_ff  <= c0 + 1'b1;
                     row_ff  <= r0;
                     slot_ff <= s0;
                  end
                  if (pend_new != '0) begin
                     state_ff <= S_JOB;
                  end
               end
            end
            S_JOB: begin
               pend_ff     <= pend_ff & ~sel_mask;
               ecol_ff     <= j_col;
               erow_ff     <= j_row;
               elast_ff    <= j_last;
               adr_ff      <= j_adr;
               half_xi_ff  <= j_half_xi;
               half_eta_ff <= j_half_eta;
               cnt_ff      <= '0;
               state_ff    <= S_RD;
            end
            S_RD: begin
               // read data arrives in the cycle after its address
               cnt_ff <= cnt_ff + 3'd1;
               case (cnt_ff)
                  3'd1, 3'd3: hold_ff <= rd_data_ff;
                  3'd2: begin
                     xk_ff <= deriv(hold_ff[31:0], rd_data_ff[31:0], half_xi_ff);
                     yk_ff <= deriv(hold_ff[63:32], rd_data_ff[63:32], half_xi_ff);
                  end
                  3'd4: begin
                     xe_ff    <= deriv(hold_ff[31:0], rd_data_ff[31:0], half_eta_ff);
                     ye_ff    <= deriv(hold_ff[63:32], rd_data_ff[63:32], half_eta_ff);
                     cnt_ff   <= '0;
                     state_ff <= S_DET;
                  end
                  default: ;
               endcase
            end
            S_DET: begin
               cnt_ff <= cnt_ff + 3'd1;
               if (cnt_ff == 3'd1) begin
                  p1_ff <= prod_ff;
               end
               if (cnt_ff == 3'd2) begin
                  det_ff   <= p1_ff - prod_ff;
                  state_ff <= S_DIVS;
               end
            end
            S_DIVS: begin
               cnt_ff <= '0;
               if (det_zero) begin
                  sing_ff  <= 1'b1;
                  inv_ff   <= SAT_POS;
                  state_ff <= S_MET;
               end else begin
                  sing_ff  <= 1'b0;
                  state_ff <= S_DIVW;
               end
            end
            S_DIVW: begin
               if (div_sts.done) begin
                  if (!det_ff[63]) begin
                     inv_ff <= (div_sts.quo > DIV_Q_W'(32'h7FFF_FFFF)) ?
                               SAT_POS : 32'(div_sts.quo);
                  end else begin
                     inv_ff <= (div_sts.quo > DIV_Q_W'(32'h8000_0000)) ?
                               SAT_NEG : -(32'(div_sts.quo));
                  end
                  state_ff <= S_MET;
               end
            end
            S_MET: begin
               cnt_ff <= cnt_ff + 3'd1;
               if (cnt_ff != 3'd0) begin
                  if (sing_ff) begin
                     met_ff[cnt_ff[1:0] - 2'd1] <= (term_prev > 0) ? SAT_POS :
                                                   (term_prev < 0) ? SAT_NEG : 32'sd0;
                  end else begin
                     met_ff[cnt_ff[1:0] - 2'd1] <= rsat(prod_ff);
                  end
               end
               if (cnt_ff == 3'd4) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_col_ff   <= COL_W'(ecol_ff);
                  rsp_row_ff   <= ROW_W'(erow_ff);
                  rsp_inv_ff   <= inv_ff;
                  rsp_met_ff   <= met_ff;
                  rsp_sing_ff  <= sing_ff;
                  rsp_last_ff  <= elast_ff;
                  state_ff     <= (pend_ff != '0) ? S_JOB : S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.col_index   = rsp_col_ff;
   assign rsp.row_index   = rsp_row_ff;
   assign rsp.inverse_det = rsp_inv_ff;
   assign rsp.xi_x        = rsp_met_ff[0];
   assign rsp.xi_y        = rsp_met_ff[1];
   assign rsp.eta_x       = rsp_met_ff[2];
   assign rsp.eta_y       = rsp_met_ff[3];
   assign rsp.singular    = rsp_sing_ff;
   assign rsp.last        = rsp_last_ff;

   // no point is taken while results of the previous one are pending
   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (pend_ff == '0))
      else $error("point accepted with results pending");

   // the divider only finishes while the sequencer waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> (state_ff == S_DIVW))
      else $error("divider finished outside its wait state");

   // a stalled output keeps the sequencer from overwriting the held beat
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && rsp_valid_ff && !rsp.ready) |=> (state_ff == S_OUT))
      else $error("output register overwritten under stall");

   // a singular result always carries the saturated reciprocal
   a_sing_inv: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.singular) |-> (rsp.inverse_det == SAT_POS))
      else $error("singular beat without saturated inverse_det");

endmodule

// ----- rtl/gms_div.sv -----
module gms_div import gms_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_ctl_type ctl,
   output div_sts_type sts
);

   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_DEN_W-1:0] rem_ff;
   logic [DIV_DEN_W-1:0] rem_in;
   logic [DIV_Q_W-1:0]   nsh_ff;
   logic [DIV_Q_W-1:0]   quo_ff;
   logic [5:0]           cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_DEN_W:0]   trial;
   logic                 qbit;

   // restoring step, one quotient bit a cycle
   always_comb begin
      trial  = {rem_ff, nsh_ff[DIV_Q_W-1]};
      qbit   = (trial >= {1'b0, den_ff});
      rem_in = qbit ? DIV_DEN_W'(trial - {1'b0, den_ff}) : DIV_DEN_W'(trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            den_ff  <= ctl.den;
            // upper numerator bits are always below the divisor
            rem_ff  <= DIV_DEN_W'(ctl.num[DIV_NUM_W-1:DIV_Q_W]);
            nsh_ff  <= ctl.num[DIV_Q_W-1:0];
            quo_ff  <= '0;
            cnt_ff  <= 6'(DIV_Q_W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            quo_ff <= {quo_ff[DIV_Q_W-2:0], qbit};
            nsh_ff <= {nsh_ff[DIV_Q_W-2:0], 1'b0};
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign sts.done = done_ff;
   assign sts.quo  = quo_ff;

endmodule
